>>> sv/dive_tissue_decompression_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tissue decompression block
// Shared clock and reset context for concurrent checks.
// ----------------------------------------------------------------------------
`ifndef DIVE_TISSUE_DECOMPRESSION_DEFINES_SVH
`define DIVE_TISSUE_DECOMPRESSION_DEFINES_SVH

// same-cycle implication
`define DTD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed (same cycle)");

// next-cycle implication
`define DTD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed (next cycle)");

`endif

>>> sv/dtd_pkg.sv
// ----------------------------------------------------------------------------
// dtd_pkg
// Types, codes and constants of the tissue decompression block.
// ----------------------------------------------------------------------------
package dtd_pkg;

	localparam int N_COMPART_DEF         = 4;
	localparam int TENSION_FRAC_BITS_DEF = 20;

	localparam int HALF_W     = 8;
	localparam int CRIT_W     = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int DEPTH_W    = 14;
	localparam int DUR_W      = 16;
	localparam int STOP_W     = 7;
	localparam int TIME_W     = 16;
	localparam int LOG_FRAC   = 24;
	localparam int MAX_STOP_Q = 42;

	localparam logic [31:0]       LN2_Q32  = 32'd2977044472;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// item commands
	localparam logic CMD_SURFACE = 1'b0;
	localparam logic CMD_SEGMENT = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HALF_C0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_C1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_C2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_C3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CRIT_C0 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CRIT_C1 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CRIT_C2 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CRIT_C3 = 3'd7;

	localparam logic [HALF_W-1:0] HALF_RST [4] = '{8'd7, 8'd30, 8'd60, 8'd120};
	localparam logic [CRIT_W-1:0] CRIT_RST [4] = '{10'd655, 10'd471, 10'd410, 10'd410};

	typedef struct packed {
		logic               cmd;
		logic [DEPTH_W-1:0] start_depth_cm;
		logic [DEPTH_W-1:0] end_depth_cm;
		logic [DUR_W-1:0]   duration_s;
	} in_item_t;

	typedef struct packed {
		logic              has_stop;
		logic [1:0]        lead_compartment;
		logic [STOP_W-1:0] stop_depth_m;
		logic [TIME_W-1:0] stop_time_s;
		logic              log_domain_error;
	} out_item_t;

endpackage

>>> sv/dive_tissue_decompression.sv
// ----------------------------------------------------------------------------
// dive_tissue_decompression
// Haldane-style tissue loading and first-stop evaluation, run by a sequencer
// over one shared multiplier and one serial divider.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  --------+----------------------------------+-----------
//  in      | in_valid, in_stall, in_data      | beat in
//  out     | out_valid, out_stall, out_data   | beat out
//  cfg     | cfg_we, cfg_index, cfg_data      | write only
//
//  One item at a time; in_stall is high from accept until the sequencer is
//  back in idle. Divisions run in the serial divider, which dominates setup
//  and evaluation. A segment then takes ceil(d/5) * n sub-interval passes,
//  each updating every tension, n being the sub-interval count. Evaluation
//  costs one division plus log2 work, with its normalization shifts, per
//  loaded compartment. Reset puts every tension at surface saturation,
//  registers at defaults. A held result in the output register only stalls
//  the final write-back.
// ----------------------------------------------------------------------------
`include "dive_tissue_decompression_defines.svh"

module dive_tissue_decompression #(
	parameter int N_COMPART         = dtd_pkg::N_COMPART_DEF,
	parameter int TENSION_FRAC_BITS = dtd_pkg::TENSION_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  dtd_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output dtd_pkg::out_item_t              out_data,
	input  logic                            cfg_we,
	input  logic [dtd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dtd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import dtd_pkg::*;

	localparam int F   = TENSION_FRAC_BITS;
	localparam int TW  = F + 4;            // tension width
	localparam int DW  = F + 52;           // divider width
	localparam int EW  = TW + 8;           // ceiling compare width
	localparam int AW  = F + 28;           // log argument width, signed
	localparam int LW  = F + 26;           // normalized log operands
	localparam int CIW = (N_COMPART > 1) ? $clog2(N_COMPART) : 1;

	localparam logic [TW-1:0] T_SURF =
		TW'(((64'd79 << F) + 64'd50) / 64'd100);
	localparam logic [TW-1:0] T_MAX = '1;

	typedef enum logic [4:0] {
		S_IDLE, S_NDIV, S_SDIV, S_M1, S_M2, S_M3, S_M4, S_M5, S_QDIV, S_IDIV,
		S_F0, S_F1, S_F2, S_F3, S_SUB, S_T0, S_T1,
		S_E0, S_E1, S_E2, S_NORM, S_LDIV, S_SQ0, S_SQ1, S_TM0, S_TM1, S_CMP, S_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic [HALF_W-1:0] half_q [4];
	logic [CRIT_W-1:0] crit_q [4];

	// item and sweep setup
	logic [DEPTH_W-1:0]   s_q;
	logic [DUR_W-1:0]     d_q;
	logic signed [14:0]   delta_q;
	logic [13:0]          ad_q;
	logic [10:0]          n_q;
	logic [13:0]          steps_q;
	logic [27:0]          d2_q;
	logic [48:0]          u0_q;
	logic [44:0]          den_q;
	logic signed [47:0]   m_q;
	logic signed [DW:0]   q_q;
	logic [44:0]          r_q;
	logic signed [DW:0]   dq_q;
	logic [44:0]          dr_q;
	logic [13:0]          kc_q;
	logic [10:0]          jc_q;
	logic [TW-1:0]        p_q;

	// factor series
	logic [31:0]          y_q;
	logic [31:0]          t_q;
	logic signed [33:0]   fa_q;
	logic [5:0]           k_q;
	logic [31:0]          f_q [N_COMPART];

	logic [TW-1:0]        tension_q [N_COMPART];
	logic [CIW-1:0]       ci_q;

	// evaluation
	logic [STOP_W-1:0]    prf_q;
	logic [LW-1:0]        la_q;
	logic [LW-1:0]        lb_q;
	logic [LW:0]          lr_q;
	logic signed [7:0]    e_q;
	logic [31:0]          x_q;
	logic [LOG_FRAC-1:0]  frac_q;
	logic [4:0]           cnt_q;
	logic [TIME_W-1:0]    tm_q;
	logic                 err_q;
	logic                 best_v_q;
	logic [1:0]           bidx_q;
	logic [STOP_W-1:0]    bd_q;
	logic [TIME_W-1:0]    bt_q;
	logic                 berr_q;

	logic                 out_valid_q;
	out_item_t            out_data_q;

	// shared units
	logic                 div_issued_q;
	logic                 div_start;
	logic                 div_done;
	logic [DW-1:0]        div_dvd;
	logic [DW-1:0]        div_dvs;
	logic [DW-1:0]        div_quo;
	logic [DW-1:0]        div_rem;
	logic [31:0]          mul_a;
	logic [31:0]          mul_b;
	logic [63:0]          prod;

	// derived
	logic signed [14:0]   in_delta;
	logic [CIW+1:0]       ci_ext;
	logic [1:0]           sel2;
	logic [HALF_W-1:0]    half_cur;
	logic [CRIT_W-1:0]    crit_cur;
	logic [TW-1:0]        t_cur;
	logic                 up;
	logic [TW-1:0]        mag;
	logic [64:0]          step_sum;
	logic [TW-1:0]        step;
	logic [45:0]          rsum;
	logic                 carry;
	logic [EW-1:0]        lhs;
	logic [EW-1:0]        rhs;
	logic [EW+3:0]        num;
	logic [EW+3:0]        den_e;
	logic [20:0]          p0;
	logic signed [AW-1:0] a_s;
	logic signed [AW-1:0] b_s;
	logic                 log_bad;
	logic signed [51:0]   n0_base;
	logic signed [33:0]   fa_nxt;
	logic [33:0]          xs;
	logic signed [31:0]   l_s;
	logic [63:0]          sec;
	logic [TW-1:0]        p_sat;
	logic                 last_ci;
	logic                 lead_upd;

	assign in_delta = $signed({1'b0, in_data.end_depth_cm}) - $signed({1'b0, in_data.start_depth_cm});
	assign ci_ext   = (CIW+2)'(ci_q);
	assign sel2     = ci_ext[1:0];
	assign half_cur = (half_q[sel2] == '0) ? HALF_W'(1) : half_q[sel2];
	assign crit_cur = (crit_q[sel2] == '0) ? CRIT_W'(1) : crit_q[sel2];
	assign t_cur    = tension_q[ci_q];
	assign last_ci  = (ci_q == CIW'(N_COMPART - 1));

	// tension update: step = round(|P - T| * f / 2^32)
	assign up       = p_q >= t_cur;
	assign mag      = up ? (p_q - t_cur) : (t_cur - p_q);
	assign step_sum = {1'b0, prod} + 65'(64'd1 << 31);
	assign step     = TW'(step_sum[64:32]);

	// rational midpoint pressure advance
	assign rsum  = {1'b0, r_q} + {1'b0, dr_q};
	assign carry = rsum >= {1'b0, den_q};

	always_comb begin
		if (q_q[DW])
			p_sat = '0;
		else if (q_q[DW-1:0] > DW'(T_MAX))
			p_sat = T_MAX;
		else
			p_sat = q_q[TW-1:0];
	end

	// ceiling and log arguments
	assign lhs   = {t_cur, 8'b0};
	assign rhs   = EW'(crit_cur) << F;
	assign num   = (EW+4)'(lhs - rhs) * (EW+4)'(10);
	assign den_e = (EW+4)'(rhs) * (EW+4)'(3);
	assign p0    = 21'(5056) * (21'(prf_q) + 21'(10));
	assign a_s   = $signed(AW'(p0) << F) - $signed(AW'(t_cur) * AW'(64000));
	assign b_s   = ($signed(AW'(p0))
		- $signed(AW'(crit_cur) * (AW'(prf_q) + AW'(7)) * AW'(25))) <<< F;
	assign log_bad = (a_s == '0) || (b_s == '0) || (a_s[AW-1] != b_s[AW-1]);

	assign n0_base = $signed(52'(u0_q)) + 52'(delta_q) * 52'sd395;
	assign fa_nxt  = k_q[0] ? (fa_q + $signed({2'b0, div_quo[31:0]}))
	                        : (fa_q - $signed({2'b0, div_quo[31:0]}));
	assign xs      = prod[63:30];
	assign l_s     = $signed({e_q, frac_q});
	assign sec     = (prod + 64'((64'd1 << LOG_FRAC) - 1)) >> LOG_FRAC;

	assign lead_upd = !best_v_q || (prf_q > bd_q) || ((prf_q == bd_q) && (tm_q > bt_q));

	// divider operand select
	always_comb begin
		div_dvd = '0;
		div_dvs = DW'(1);
		case (state_q)
			S_NDIV: begin
				div_dvd = DW'(ad_q);
				div_dvs = DW'(d_q) * DW'(10);
			end
			S_QDIV: begin
				div_dvd = (DW'(n0_base) << F) + DW'(den_q >> 1);
				div_dvs = DW'(den_q);
			end
			S_IDIV: begin
				div_dvd = (DW'(ad_q) * DW'(790)) << F;
				div_dvs = DW'(den_q);
			end
			S_F1: begin
				div_dvd = DW'(LN2_Q32) + DW'(prod[31:0]) * DW'(6);
				div_dvs = DW'(prod[31:0]) * DW'(12);
			end
			S_F3: begin
				div_dvd = DW'(prod[63:32]);
				div_dvs = DW'(k_q);
			end
			S_E1: begin
				div_dvd = DW'(num) + DW'(den_e) - DW'(1);
				div_dvs = DW'(den_e);
			end
			default: ;
		endcase
	end

	assign div_start = !div_issued_q && ((state_q == S_NDIV)
		|| (state_q == S_QDIV) || (state_q == S_IDIV) || (state_q == S_F1)
		|| (state_q == S_F3) || (state_q == S_E1));

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SDIV: begin
				// ceil(d/5) = floor((d+4) * ceil(2^22/5) / 2^22), exact for 17 bits
				mul_a = 32'(d_q) + 32'd4;
				mul_b = 32'd838861;
			end
			S_M1: begin
				mul_a = 32'(n_q);
				mul_b = 32'(d_q);
			end
			S_M2: begin
				mul_a = (32'(s_q) + 32'd1000) * 32'd79;
				mul_b = {prod[30:0], 1'b0};
			end
			S_M3: begin
				mul_a = 32'(d2_q);
				mul_b = 32'd100000;
			end
			S_M4: begin
				mul_a = 32'(s_q) + 32'd1000;
				mul_b = 32'(d2_q);
			end
			S_F0: begin
				mul_a = 32'(n_q);
				mul_b = 32'(half_cur);
			end
			S_F2: begin
				mul_a = t_q;
				mul_b = y_q;
			end
			S_T0: begin
				mul_a = 32'(mag);
				mul_b = f_q[ci_q];
			end
			S_SQ0: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			S_TM0: begin
				mul_a = l_s;
				mul_b = 32'(half_cur) * 32'd60;
			end
			default: ;
		endcase
	end

	dtd_div #(.W(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	dtd_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < 4; i++) begin
				half_q[i] <= HALF_RST[i];
				crit_q[i] <= CRIT_RST[i];
			end
			for (int i = 0; i < N_COMPART; i++) begin
				tension_q[i] <= T_SURF;
				f_q[i]       <= '0;
			end
			s_q <= '0; d_q <= '0; delta_q <= '0; ad_q <= '0;
			n_q <= '0; steps_q <= '0; d2_q <= '0; u0_q <= '0; den_q <= '0;
			m_q <= '0; q_q <= '0; r_q <= '0; dq_q <= '0; dr_q <= '0;
			kc_q <= '0; jc_q <= '0; p_q <= '0;
			y_q <= '0; t_q <= '0; fa_q <= '0; k_q <= '0; ci_q <= '0;
			prf_q <= '0; la_q <= '0; lb_q <= '0; lr_q <= '0; e_q <= '0;
			x_q <= '0; frac_q <= '0; cnt_q <= '0; tm_q <= '0; err_q <= 1'b0;
			best_v_q <= 1'b0; bidx_q <= '0; bd_q <= '0; bt_q <= '0; berr_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			div_issued_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_HALF_C0: half_q[0] <= cfg_data[HALF_W-1:0];
					REG_HALF_C1: half_q[1] <= cfg_data[HALF_W-1:0];
					REG_HALF_C2: half_q[2] <= cfg_data[HALF_W-1:0];
					REG_HALF_C3: half_q[3] <= cfg_data[HALF_W-1:0];
					REG_CRIT_C0: crit_q[0] <= cfg_data;
					REG_CRIT_C1: crit_q[1] <= cfg_data;
					REG_CRIT_C2: crit_q[2] <= cfg_data;
					REG_CRIT_C3: crit_q[3] <= cfg_data;
					default: ;
				endcase
			end

			// write-back state loads the register itself
			if (out_valid_q && !out_stall && (state_q != S_FIN))
				out_valid_q <= 1'b0;

			if (div_start)
				div_issued_q <= 1'b1;
			else if (div_done)
				div_issued_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						s_q     <= in_data.start_depth_cm;
						d_q     <= in_data.duration_s;
						delta_q <= in_delta;
						ad_q    <= 14'(in_delta[14] ? -in_delta : in_delta);
						ci_q    <= '0;
						best_v_q <= 1'b0;
						bidx_q  <= '0;
						bd_q    <= '0;
						bt_q    <= '0;
						berr_q  <= 1'b0;
						if (in_data.cmd == CMD_SURFACE) begin
							for (int i = 0; i < N_COMPART; i++)
								tension_q[i] <= T_SURF;
							state_q <= S_E0;
						end else if (in_data.duration_s == '0) begin
							state_q <= S_E0;
						end else begin
							state_q <= S_NDIV;
						end
					end
				end
				S_NDIV: begin
					if (div_done) begin
						n_q     <= (div_quo == '0) ? 11'd1 : div_quo[10:0];
						state_q <= S_SDIV;
					end
				end
				S_SDIV: state_q <= S_M1;
				S_M1: begin
					steps_q <= prod[35:22];
					state_q <= S_M2;
				end
				S_M2: begin
					d2_q    <= {prod[26:0], 1'b0};
					state_q <= S_M3;
				end
				S_M3: begin
					u0_q    <= prod[48:0];
					state_q <= S_M4;
				end
				S_M4: begin
					den_q   <= prod[44:0];
					state_q <= S_M5;
				end
				S_M5: begin
					m_q     <= $signed({1'b0, prod[46:0]}) + 48'(delta_q) * 48'sd5;
					state_q <= S_QDIV;
				end
				S_QDIV: begin
					if (div_done) begin
						q_q     <= $signed({1'b0, div_quo});
						r_q     <= div_rem[44:0];
						state_q <= S_IDIV;
					end
				end
				S_IDIV: begin
					if (div_done) begin
						// floor division for a falling ramp
						if (!delta_q[14]) begin
							dq_q <= $signed({1'b0, div_quo});
							dr_q <= div_rem[44:0];
						end else if (div_rem == '0) begin
							dq_q <= -$signed({1'b0, div_quo});
							dr_q <= '0;
						end else begin
							dq_q <= -$signed({1'b0, div_quo}) - 1;
							dr_q <= den_q - div_rem[44:0];
						end
						ci_q    <= '0;
						state_q <= S_F0;
					end
				end
				S_F0: state_q <= S_F1;
				S_F1: begin
					if (div_done) begin
						y_q     <= div_quo[31:0];
						t_q     <= div_quo[31:0];
						fa_q    <= $signed({2'b0, div_quo[31:0]});
						k_q     <= 6'd2;
						state_q <= S_F2;
					end
				end
				S_F2: state_q <= S_F3;
				S_F3: begin
					if (div_done) begin
						t_q  <= div_quo[31:0];
						fa_q <= fa_nxt;
						if (div_quo[31:0] == '0) begin
							f_q[ci_q] <= fa_nxt[33] ? 32'd0 : fa_nxt[31:0];
							if (last_ci) begin
								kc_q    <= '0;
								jc_q    <= '0;
								state_q <= S_SUB;
							end else begin
								ci_q    <= ci_q + 1'b1;
								state_q <= S_F0;
							end
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_F2;
						end
					end
				end
				S_SUB: begin
					p_q     <= (m_q > 0) ? p_sat : '0;
					ci_q    <= '0;
					state_q <= S_T0;
				end
				S_T0: state_q <= S_T1;
				S_T1: begin
					tension_q[ci_q] <= up ? (t_cur + step) : (t_cur - step);
					if (last_ci) begin
						m_q <= m_q + 48'(delta_q) * 48'sd10;
						r_q <= carry ? 45'(rsum - {1'b0, den_q}) : rsum[44:0];
						q_q <= q_q + dq_q + $signed({{DW{1'b0}}, carry});
						ci_q <= '0;
						if (jc_q == n_q - 1'b1) begin
							jc_q <= '0;
							if (kc_q == steps_q - 1'b1) begin
								state_q <= S_E0;
							end else begin
								kc_q    <= kc_q + 1'b1;
								state_q <= S_SUB;
							end
						end else begin
							jc_q    <= jc_q + 1'b1;
							state_q <= S_SUB;
						end
					end else begin
						ci_q    <= ci_q + 1'b1;
						state_q <= S_T0;
					end
				end
				S_E0: begin
					if (lhs > rhs) begin
						state_q <= S_E1;
					end else if (last_ci) begin
						state_q <= S_FIN;
					end else begin
						ci_q <= ci_q + 1'b1;
					end
				end
				S_E1: begin
					if (div_done) begin
						if (div_quo > DW'(MAX_STOP_Q))
							prf_q <= STOP_W'(3 * MAX_STOP_Q);
						else
							prf_q <= div_quo[STOP_W-1:0] * STOP_W'(3);
						state_q <= S_E2;
					end
				end
				S_E2: begin
					if (log_bad) begin
						tm_q    <= TIME_MAX;
						err_q   <= 1'b1;
						state_q <= S_CMP;
					end else begin
						la_q    <= LW'(a_s[AW-1] ? -a_s : a_s);
						lb_q    <= LW'(b_s[AW-1] ? -b_s : b_s);
						e_q     <= '0;
						tm_q    <= '0;
						err_q   <= 1'b0;
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					// bring a/b into [1, 2)
					if (la_q < lb_q) begin
						la_q <= la_q << 1;
						e_q  <= e_q - 1'b1;
					end else if ({1'b0, la_q} >= {lb_q, 1'b0}) begin
						lb_q <= lb_q << 1;
						e_q  <= e_q + 1'b1;
					end else begin
						lr_q    <= {1'b0, la_q - lb_q};
						x_q     <= 32'd1 << 30;
						cnt_q   <= 5'd29;
						state_q <= S_LDIV;
					end
				end
				S_LDIV: begin
					if ((lr_q << 1) >= {1'b0, lb_q}) begin
						lr_q       <= (lr_q << 1) - {1'b0, lb_q};
						x_q[cnt_q] <= 1'b1;
					end else begin
						lr_q <= lr_q << 1;
					end
					if (cnt_q == '0) begin
						frac_q  <= '0;
						cnt_q   <= 5'(LOG_FRAC - 1);
						state_q <= S_SQ0;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_SQ0: state_q <= S_SQ1;
				S_SQ1: begin
					if (xs[31]) begin
						x_q           <= {1'b0, xs[31:1]};
						frac_q[cnt_q] <= 1'b1;
					end else begin
						x_q <= xs[31:0];
					end
					if (cnt_q == '0) begin
						state_q <= S_TM0;
					end else begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_SQ0;
					end
				end
				S_TM0: begin
					if (l_s > 0) begin
						state_q <= S_TM1;
					end else begin
						tm_q    <= '0;
						state_q <= S_CMP;
					end
				end
				S_TM1: begin
					tm_q    <= (sec > 64'(TIME_MAX)) ? TIME_MAX : sec[TIME_W-1:0];
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (lead_upd) begin
						best_v_q <= 1'b1;
						bidx_q   <= sel2;
						bd_q     <= prf_q;
						bt_q     <= tm_q;
						berr_q   <= err_q;
					end
					if (last_ci) begin
						state_q <= S_FIN;
					end else begin
						ci_q    <= ci_q + 1'b1;
						state_q <= S_E0;
					end
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						if (best_v_q) begin
							out_data_q.has_stop         <= 1'b1;
							out_data_q.lead_compartment <= bidx_q;
							out_data_q.stop_depth_m     <= bd_q;
							out_data_q.stop_time_s      <= bt_q;
							out_data_q.log_domain_error <= berr_q;
						end else begin
							out_data_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`DTD_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`DTD_ASSERT_IMP(a_err_saturates, out_valid && out_data.log_domain_error, out_data.has_stop && (out_data.stop_time_s == TIME_MAX))
	`DTD_ASSERT_IMP(a_no_stop_clear, out_valid && !out_data.has_stop, (out_data.stop_depth_m == '0) && (out_data.stop_time_s == '0) && (out_data.lead_compartment == '0))

endmodule

>>> sv/dtd_div.sv
// ----------------------------------------------------------------------------
// dtd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dtd_div #(
	parameter int W = 72
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);
	import dtd_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [W:0]    rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    sh;
	logic          ge;

	assign sh = {rem_q[W-1:0], quo_q[W-1]};
	assign ge = sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dvs_q  <= divisor;
			cnt_q  <= CW'(W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= ge ? (sh - {1'b0, dvs_q}) : sh;
			quo_q <= {quo_q[W-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q[W-1:0];

endmodule

>>> sv/dtd_mul.sv
// ----------------------------------------------------------------------------
// dtd_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module dtd_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] prod
);
	import dtd_pkg::*;

	logic [63:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= 64'(a) * 64'(b);
	end

	assign prod = prod_q;

endmodule
